FILE: rtl/mocdb_pkg.sv
// Shared types and constants for the multiplexed occupancy debouncer.
// No dependencies; imported by the top module, mocdb_update and the testbench.
`default_nettype none

package mocdb_pkg;

  localparam int MAX_DETECTORS_DEF = 8;
  localparam int BLOCKS_PER_DET    = 8;
  localparam int BLK_W             = 3;
  localparam int TIME_W            = 32;
  localparam int SUM_W             = 16;
  localparam int DEBOUNCE_W        = 16;
  localparam int SAMPLES_W         = 7;
  localparam int DETS_W            = 4;
  localparam int THRESH_W          = 10;
  localparam int PRODUCT_W         = THRESH_W + SAMPLES_W;
  localparam int CFG_DATA_W        = 16;
  localparam int CFG_IDX_W         = 2;
  localparam int IN_DATA_W         = 48;
  localparam int OUT_DATA_W        = 16;
  localparam int SCAN_DET_W        = 3;
  localparam int ABS_BLK_W         = 6;

  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST = DEBOUNCE_W'(50);
  localparam logic [SAMPLES_W-1:0]  SAMPLES_RST  = SAMPLES_W'(1);
  localparam logic [DETS_W-1:0]     DETS_RST     = DETS_W'(1);
  localparam logic [THRESH_W-1:0]   THRESH_RST   = THRESH_W'(600);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE  = 2'd0,
    REG_SAMPLES   = 2'd1,
    REG_DETECTORS = 2'd2,
    REG_THRESHOLD = 2'd3
  } cfg_reg_t;

  // per-channel record held in the channel RAM
  typedef struct packed {
    logic              stable;
    logic              raw;
    logic [TIME_W-1:0] change_time;
  } chan_entry_t;

  localparam int ENTRY_W = $bits(chan_entry_t);

  typedef struct packed {
    chan_entry_t wr;
    logic        changed;
    logic        occupied;
  } chan_upd_t;

endpackage

`default_nettype wire

FILE: rtl/multiplexed_occupancy_debouncer.sv
// Multiplexed occupancy debouncer: scans one channel per request, debounces it.
// Requests pass the stage-1 and result registers; one request per cycle sustained
// while results are taken; set by the channel RAM read-modify-write over two stages.
// Reset (rst_n low, synchronous): config to defaults, scan from channel 0, all
// channel records read as zero via per-channel valid bits.
`default_nettype none

module multiplexed_occupancy_debouncer import mocdb_pkg::*; #(
  parameter int MAX_DETECTORS = MAX_DETECTORS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output      logic                  in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // now_ms[31:0], level_sum[47:32]
  output      logic                  out_tvalid,
  input  wire logic                  out_tready,
  output      logic [OUT_DATA_W-1:0] out_tdata,  // scan_block[2:0], scan_detector[5:3],
                                                 // absolute_block[11:6], now_occupied[12]
  output      logic                  out_tuser,  // changed
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CHANNELS = MAX_DETECTORS * BLOCKS_PER_DET;
  localparam int DET_W    = (MAX_DETECTORS > 1) ? $clog2(MAX_DETECTORS) : 1;
  localparam int CNT_W    = (DET_W + 1 > DETS_W) ? DET_W + 1 : DETS_W;
  localparam int CH_W     = DET_W + BLK_W;
  localparam int RAM_AW   = $clog2(CHANNELS);
  localparam int DEXT_W   = DET_W + SCAN_DET_W;
  localparam int CEXT_W   = CH_W + ABS_BLK_W;

  // configuration
  logic [DEBOUNCE_W-1:0] debounce_r;
  logic [SAMPLES_W-1:0]  samples_r;
  logic [DETS_W-1:0]     dets_r;
  logic [THRESH_W-1:0]   thresh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= DEBOUNCE_RST;
      samples_r  <= SAMPLES_RST;
      dets_r     <= DETS_RST;
      thresh_r   <= THRESH_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_DEBOUNCE:  debounce_r <= cfg_wdata[DEBOUNCE_W-1:0];
        REG_SAMPLES:   samples_r  <= cfg_wdata[SAMPLES_W-1:0];
        REG_DETECTORS: dets_r     <= cfg_wdata[DETS_W-1:0];
        REG_THRESHOLD: thresh_r   <= cfg_wdata[THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  logic [CNT_W-1:0] det_count;
  always_comb begin
    det_count = CNT_W'(dets_r);
    if (dets_r == '0) begin
      det_count = CNT_W'(1);
    end
    if (det_count > CNT_W'(MAX_DETECTORS)) begin
      det_count = CNT_W'(MAX_DETECTORS);
    end
  end

  logic [SAMPLES_W-1:0] samples_eff;
  logic [PRODUCT_W-1:0] level_limit;
  assign samples_eff = (samples_r == '0) ? SAMPLES_W'(1) : samples_r;
  assign level_limit = PRODUCT_W'(thresh_r) * PRODUCT_W'(samples_eff);

  // stage 0: request accept, scan counters, RAM read
  logic              accept;
  logic [TIME_W-1:0] in_now;
  logic [SUM_W-1:0]  in_sum;
  logic              in_occ;
  assign in_now = in_tdata[TIME_W-1:0];
  assign in_sum = in_tdata[TIME_W +: SUM_W];
  assign in_occ = PRODUCT_W'(in_sum) < level_limit;

  logic [DET_W-1:0] det_cnt_r, det_cnt_nxt, det_cur;
  logic [BLK_W-1:0] blk_cnt_r, blk_cnt_nxt, blk_cur;
  logic [CNT_W-1:0] det_inc;
  logic [CH_W-1:0]  ch_cur;

  always_comb begin
    det_cur = det_cnt_r;
    blk_cur = blk_cnt_r;
    if (CNT_W'(det_cnt_r) >= det_count) begin
      det_cur = '0;
      blk_cur = '0;
    end
    ch_cur      = {det_cur, blk_cur};
    blk_cnt_nxt = blk_cur + BLK_W'(1);
    det_inc     = CNT_W'(det_cur) + CNT_W'(1);
    det_cnt_nxt = det_cur;
    if (blk_cnt_nxt == '0) begin
      det_cnt_nxt = (det_inc >= det_count) ? '0 : det_inc[DET_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      det_cnt_r <= '0;
      blk_cnt_r <= '0;
    end else if (accept) begin
      det_cnt_r <= det_cnt_nxt;
      blk_cnt_r <= blk_cnt_nxt;
    end
  end

  // stage 1: channel record available, debounce update, write back
  logic              s1_v_r;
  logic [TIME_W-1:0] s1_now_r;
  logic              s1_occ_r;
  logic [CH_W-1:0]   s1_ch_r;
  logic              s1_vld_r;
  logic              s1_adv;

  logic              out_v_r;
  logic [BLK_W-1:0]  out_blk_r;
  logic [DET_W-1:0]  out_det_r;
  logic [CH_W-1:0]   out_ch_r;
  logic              out_chg_r;
  logic              out_occ_r;

  logic [CHANNELS-1:0] vld_r;
  logic [ENTRY_W-1:0]  ram_rdata;
  chan_entry_t         cur_entry;
  chan_upd_t           upd;

  assign s1_adv    = s1_v_r && (!out_v_r || out_tready);
  assign in_tready = !s1_v_r || !out_v_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (accept) begin
      s1_v_r <= 1'b1;
    end else if (s1_adv) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_now_r <= in_now;
      s1_occ_r <= in_occ;
      s1_ch_r  <= ch_cur;
      s1_vld_r <= vld_r[ch_cur[RAM_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (s1_adv) begin
      vld_r[s1_ch_r[RAM_AW-1:0]] <= 1'b1;
    end
  end

  mocdb_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CHANNELS)
  ) u_chan_ram (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_ch_r[RAM_AW-1:0]),
    .wdata (upd.wr),
    .re    (accept),
    .raddr (ch_cur[RAM_AW-1:0]),
    .rdata (ram_rdata)
  );

  assign cur_entry = s1_vld_r ? chan_entry_t'(ram_rdata) : '0;

  mocdb_update u_update (
    .cur         (cur_entry),
    .occ         (s1_occ_r),
    .now_ms      (s1_now_r),
    .debounce_ms (debounce_r),
    .upd         (upd)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_adv) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_blk_r <= s1_ch_r[BLK_W-1:0];
      out_det_r <= s1_ch_r[CH_W-1:BLK_W];
      out_ch_r  <= s1_ch_r;
      out_chg_r <= upd.changed;
      out_occ_r <= upd.occupied;
    end
  end

  logic [DEXT_W-1:0]    det_ext;
  logic [CEXT_W-1:0]    ch_ext;
  logic [ABS_BLK_W-1:0] abs_blk;
  assign det_ext = DEXT_W'(out_det_r);
  assign ch_ext  = CEXT_W'(out_ch_r);
  assign abs_blk = out_chg_r ? ch_ext[ABS_BLK_W-1:0] : '0;

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_chg_r;
  assign out_tdata  = {3'b000, out_occ_r, abs_blk, det_ext[SCAN_DET_W-1:0], out_blk_r};

  // checks
  a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && accept) |-> (s1_ch_r != ch_cur))
    else $error("channel RAM read and write hit the same channel");

  a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> s1_v_r)
    else $error("accepted request lost before the update stage");

  a_event_matches_block: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata[8:6] == out_tdata[2:0]))
    else $error("event channel disagrees with scanned block");

  a_event_settles: assert property (@(posedge clk) disable iff (!rst_n)
    upd.changed |-> (upd.wr.raw == upd.wr.stable))
    else $error("stable bit changed away from raw bit");

endmodule

`default_nettype wire

FILE: rtl/mocdb_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
`default_nettype none

module mocdb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/mocdb_update.sv
// Debounce decision for one channel: raw change, hold-time check, stable update.
// Depends on mocdb_pkg.
`default_nettype none

module mocdb_update import mocdb_pkg::*; (
  input  wire chan_entry_t           cur,
  input  wire logic                  occ,
  input  wire logic [TIME_W-1:0]     now_ms,
  input  wire logic [DEBOUNCE_W-1:0] debounce_ms,
  output      chan_upd_t             upd
);

  logic [TIME_W-1:0] elapsed;
  logic              held;

  assign elapsed = now_ms - cur.change_time;
  assign held    = elapsed > TIME_W'(debounce_ms);

  always_comb begin
    upd          = '0;
    upd.wr       = cur;
    if (cur.raw != occ) begin
      upd.wr.raw         = occ;
      upd.wr.change_time = now_ms;
    end else if (held && (cur.stable != occ)) begin
      upd.wr.stable = occ;
      upd.changed   = 1'b1;
      upd.occupied  = occ;
    end
  end

endmodule

`default_nettype wire

FILE: sim/occupancy_monitor.sv
// Checker for the multiplexed occupancy debouncer: watches the request, result
// and register-write ports, predicts every scan result and compares field by field.
// Depends on mocdb_pkg for widths and register codes.
module occupancy_monitor import mocdb_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  input  wire logic                  in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  input  wire logic                  out_tvalid,
  input  wire logic                  out_tready,
  input  wire logic [OUT_DATA_W-1:0] out_tdata,
  input  wire logic                  out_tuser,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                         fail_count,
  output int                         pending,
  output int                         results_seen,
  output int                         events_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CHANNELS = MAX_DETECTORS_DEF * BLOCKS_PER_DET;

  typedef struct packed {
    logic [BLK_W-1:0]      blk;
    logic [SCAN_DET_W-1:0] det;
    logic                  changed;
    logic [ABS_BLK_W-1:0]  abs_blk;
    logic                  occupied;
  } scan_result_t;

  logic [DEBOUNCE_W-1:0] hold_ms;
  logic [SAMPLES_W-1:0]  samples;
  logic [DETS_W-1:0]     detectors;
  logic [THRESH_W-1:0]   threshold;

  logic                  raw_occ    [CHANNELS];
  logic [TIME_W-1:0]     raw_since  [CHANNELS];
  logic                  stable_occ [CHANNELS];
  logic [BLK_W-1:0]      next_blk;
  logic [SCAN_DET_W-1:0] next_det;

  scan_result_t expected_scans[$];

  initial begin
    fail_count   = 0;
    pending      = 0;
    results_seen = 0;
    events_seen  = 0;
  end

  function automatic scan_result_t debounce_scan(input logic [TIME_W-1:0] now,
                                                 input logic [SUM_W-1:0] level);
    scan_result_t        r;
    logic [DETS_W-1:0]    n_det;
    logic [SAMPLES_W-1:0] n_samp;
    logic [PRODUCT_W-1:0] limit;
    logic [ABS_BLK_W-1:0] ch;
    logic [TIME_W-1:0]    elapsed;
    logic                 occ;
    n_det  = (detectors == '0) ? DETS_W'(1) :
             (detectors > DETS_W'(MAX_DETECTORS_DEF)) ? DETS_W'(MAX_DETECTORS_DEF) : detectors;
    n_samp = (samples == '0) ? SAMPLES_W'(1) : samples;
    if ({1'b0, next_det} >= n_det) begin
      next_det = '0;
      next_blk = '0;
    end
    ch      = {next_det, next_blk};
    limit   = PRODUCT_W'(threshold) * PRODUCT_W'(n_samp);
    occ     = PRODUCT_W'(level) < limit;
    elapsed = now - raw_since[ch];
    r       = '0;
    r.blk   = next_blk;
    r.det   = next_det;
    if (raw_occ[ch] != occ) begin
      raw_occ[ch]   = occ;
      raw_since[ch] = now;
    end else if (elapsed > TIME_W'(hold_ms) && stable_occ[ch] != occ) begin
      stable_occ[ch] = occ;
      r.changed      = 1'b1;
      r.abs_blk      = ch;
      r.occupied     = occ;
    end
    next_blk = next_blk + 1'b1;
    if (next_blk == '0) begin
      next_det = ({1'b0, next_det} + DETS_W'(1) >= n_det) ? '0 : next_det + 1'b1;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    scan_result_t got;
    scan_result_t want;
    if (!rst_n) begin
      hold_ms   = DEBOUNCE_RST;
      samples   = SAMPLES_RST;
      detectors = DETS_RST;
      threshold = THRESH_RST;
      for (int i = 0; i < CHANNELS; i++) begin
        raw_occ[i]    = 1'b0;
        raw_since[i]  = '0;
        stable_occ[i] = 1'b0;
      end
      next_blk = '0;
      next_det = '0;
      expected_scans.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_addr))
          REG_DEBOUNCE:  hold_ms   = cfg_wdata[DEBOUNCE_W-1:0];
          REG_SAMPLES:   samples   = cfg_wdata[SAMPLES_W-1:0];
          REG_DETECTORS: detectors = cfg_wdata[DETS_W-1:0];
          REG_THRESHOLD: threshold = cfg_wdata[THRESH_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        expected_scans.push_back(debounce_scan(in_tdata[31:0], in_tdata[47:32]));
      if (out_tvalid && out_tready) begin
        got.blk      = out_tdata[2:0];
        got.det      = out_tdata[5:3];
        got.abs_blk  = out_tdata[11:6];
        got.occupied = out_tdata[12];
        got.changed  = out_tuser;
        results_seen++;
        if (got.changed) events_seen++;
        if (expected_scans.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected result blk=%0d det=%0d chg=%0d abs=%0d occ=%0d",
                     $realtime, got.blk, got.det, got.changed, got.abs_blk, got.occupied);
        end else begin
          want = expected_scans.pop_front();
          if (got.blk !== want.blk || got.det !== want.det || got.changed !== want.changed ||
              got.abs_blk !== want.abs_blk || got.occupied !== want.occupied) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("%0t: result %0d expected blk=%0d det=%0d chg=%0d abs=%0d occ=%0d",
                       $realtime, results_seen, want.blk, want.det, want.changed,
                       want.abs_blk, want.occupied);
              $display("%0t: result %0d got      blk=%0d det=%0d chg=%0d abs=%0d occ=%0d",
                       $realtime, results_seen, got.blk, got.det, got.changed,
                       got.abs_blk, got.occupied);
            end
          end
        end
      end
    end
    pending = expected_scans.size();
  end

endmodule

FILE: sim/tb.sv
// Top of the occupancy debouncer testbench: clock, reset, scan request and
// register-write stimulus, result back-pressure and the final verdict.
// Depends on mocdb_pkg, the block itself and occupancy_monitor.
module tb import mocdb_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TARGET_SCANS = 1400;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;   // now_ms[31:0], level_sum[47:32]
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;  // scan_block[2:0], scan_detector[5:3],
                                     // absolute_block[11:6], now_occupied[12]
  logic                  out_tuser;  // changed
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int fail_count, pending, results_seen, events_seen;
  int stall_left = 0;
  bit out_calm   = 1'b0;
  bit in_calm    = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  multiplexed_occupancy_debouncer dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .out_tvalid, .out_tready,
    .out_tdata, .out_tuser, .cfg_we, .cfg_addr, .cfg_wdata
  );

  occupancy_monitor monitor (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .out_tvalid, .out_tready,
    .out_tdata, .out_tuser, .cfg_we, .cfg_addr, .cfg_wdata,
    .fail_count, .pending, .results_seen, .events_seen
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // result back-pressure
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_tready <= 1'b1;
      if (!out_calm && $urandom_range(0, 3) == 0) stall_left <= pick_gap();
    end
    if ($urandom_range(0, 199) == 0) out_calm <= !out_calm;
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_scan(input logic [TIME_W-1:0] now, input logic [SUM_W-1:0] level);
    int gap;
    in_tdata  <= {level, now};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    gap = in_calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic write_reg(input cfg_reg_t idx, input int value, input int width);
    logic [31:0] junk;
    junk      = $urandom;
    junk      = junk << width;
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= CFG_DATA_W'(value) | junk[CFG_DATA_W-1:0];
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic int pick_level(input bit occ, input int limit);
    int r;
    r = $urandom_range(0, 7);
    if (occ && limit > 0) begin
      if (r == 0) return 0;
      if (r == 1) return limit - 1;
      return $urandom_range(0, limit - 1);
    end
    if (limit > 65535) return $urandom_range(0, 65535);
    if (r == 0) return 65535;
    if (r == 1) return limit;
    return $urandom_range(limit, 65535);
  endfunction

  initial begin
    logic [TIME_W-1:0] now;
    int sent, phase, items;
    int hold, samp, dets, thr, n_eff, samp_eff, limit, step_max, run_left;
    bit wrap, want_occ, occ;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_we    = 1'b0;
    cfg_addr  = REG_DEBOUNCE;
    cfg_wdata = '0;
    sent      = 0;
    run_left  = 0;
    want_occ  = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: raw change, hold exactly equal to debounce, then just over
    for (int i = 0; i < 8; i++) send_scan(32'd10, 16'd0);
    for (int i = 0; i < 8; i++) send_scan(32'd60, 16'd599);
    for (int i = 0; i < 8; i++) send_scan(32'd61, i[0] ? 16'd65535 : 16'd598);
    sent = 24;
    now  = 32'd61;

    phase = 0;
    while (sent < TARGET_SCANS) begin
      drain();
      wrap = 1'b0;
      case (phase)
        0: begin hold = 0;     samp = 1;   dets = 1;  thr = 600;  end
        1: begin hold = 65535; samp = 64;  dets = 2;  thr = 1023; end
        2: begin hold = 20;    samp = 0;   dets = 0;  thr = 0;    end
        3: begin hold = 100;   samp = 127; dets = 15; thr = 1023; end
        4: begin hold = 300;   samp = 5;   dets = 3;  thr = 512;  wrap = 1'b1; end
        5: begin hold = 7;     samp = 64;  dets = 9;  thr = 1;    end
        default: begin
          hold = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 600);
          samp = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 64);
          dets = (phase == 6) ? 8 : $urandom_range(0, 15);
          thr  = $urandom_range(0, 1023);
          wrap = $urandom_range(0, 3) == 0;
        end
      endcase
      write_reg(REG_DEBOUNCE, hold, DEBOUNCE_W);
      write_reg(REG_SAMPLES, samp, SAMPLES_W);
      write_reg(REG_DETECTORS, dets, DETS_W);
      write_reg(REG_THRESHOLD, thr, THRESH_W);
      cfg_we <= 1'b0;

      n_eff    = (dets == 0) ? 1 : (dets > MAX_DETECTORS_DEF) ? MAX_DETECTORS_DEF : dets;
      samp_eff = (samp == 0) ? 1 : samp;
      limit    = thr * samp_eff;
      step_max = hold / (4 * n_eff) + 3;
      items    = 80 + 16 * n_eff;
      in_calm  = $urandom_range(0, 3) == 0;
      if (wrap) now = 32'hFFFF_FFFF - $urandom_range(0, 4000);

      for (int i = 0; i < items; i++) begin
        if (run_left == 0) begin
          want_occ = !want_occ;
          run_left = $urandom_range(4, 120);
        end
        run_left--;
        occ = want_occ ^ ($urandom_range(0, 9) == 0);
        if ($urandom_range(0, 24) == 0) now = $urandom;
        else now = now + $urandom_range(0, step_max);
        send_scan(now, SUM_W'(pick_level(occ, limit)));
        sent++;
      end
      phase++;
    end

    drain();
    repeat (6) @(posedge clk);
    $display("Covered %0d scan requests over %0d register settings after the directed part;",
             sent, phase);
    $display("%0d results compared, %0d of them debounced occupancy events.",
             results_seen, events_seen);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
